// ===== hw/rtl/utf8tf_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8tf_pkg
// Shared types and constants of the UTF-8 tiny font glyph layout block.
// ----------------------------------------------------------------------------
package utf8tf_pkg;

  // Field widths of the result word.
  localparam int GLYPH_W = 7;
  localparam int WIDTH_W = 3;
  localparam int XPOS_W  = 13;
  localparam int COUNT_W = 9;
  localparam int OFFS_W  = 12;
  localparam int BASE_W  = 8;

  // Default line length limit in bytes.
  localparam int LINE_BYTES_DEF = 256;

  // Saturation limits of the running line state.
  localparam logic [OFFS_W-1:0]  OFFSET_MAX = 12'd2047;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 9'd511;

  // Terminator bytes.
  localparam logic [7:0] BYTE_NUL = 8'h00;
  localparam logic [7:0] BYTE_LF  = 8'h0A;

  // Code points and ranges of the glyph map.
  localparam logic [15:0] CODE_UP_A     = 16'h0041;
  localparam logic [15:0] CODE_UP_Z     = 16'h005A;
  localparam logic [15:0] CODE_LO_A     = 16'h0061;
  localparam logic [15:0] CODE_LO_Z     = 16'h007A;
  localparam logic [15:0] CODE_PUNCT_LO = 16'h0021;
  localparam logic [15:0] CODE_PUNCT_HI = 16'h0040;
  localparam logic [15:0] CODE_DEL      = 16'h007F;
  localparam logic [15:0] CODE_CYR_UP_LO = 16'hD090;
  localparam logic [15:0] CODE_CYR_UP_HI = 16'hD0AF;
  localparam logic [15:0] CODE_CYR_LA_LO = 16'hD0B0;
  localparam logic [15:0] CODE_CYR_LA_HI = 16'hD0BF;
  localparam logic [15:0] CODE_CYR_LB_LO = 16'hD180;
  localparam logic [15:0] CODE_CYR_LB_HI = 16'hD18F;
  localparam logic [15:0] CODE_IO_UP    = 16'hD081;
  localparam logic [15:0] CODE_IO_LO    = 16'hD191;
  localparam logic [15:0] CODE_YE_UP    = 16'hD084;
  localparam logic [15:0] CODE_YE_LO    = 16'hD194;
  localparam logic [15:0] CODE_I_UP     = 16'hD086;
  localparam logic [15:0] CODE_I_LO     = 16'hD196;
  localparam logic [15:0] CODE_YI_UP    = 16'hD087;
  localparam logic [15:0] CODE_YI_LO    = 16'hD197;
  localparam logic [15:0] CODE_GHE_UP   = 16'hD290;
  localparam logic [15:0] CODE_GHE_LO   = 16'hD291;
  localparam logic [15:0] CODE_DEGREE   = 16'hC2B0;

  // Glyph numbers.
  localparam logic [GLYPH_W-1:0] GLYPH_BLANK  = 7'd0;
  localparam logic [GLYPH_W-1:0] GLYPH_PUNCT0 = 7'd27;
  localparam logic [GLYPH_W-1:0] GLYPH_CYR0   = 7'd59;
  localparam logic [GLYPH_W-1:0] GLYPH_CYR16  = 7'd75;
  localparam logic [GLYPH_W-1:0] GLYPH_IO     = 7'd64;
  localparam logic [GLYPH_W-1:0] GLYPH_YE     = 7'd91;
  localparam logic [GLYPH_W-1:0] GLYPH_I      = 7'd9;
  localparam logic [GLYPH_W-1:0] GLYPH_YI     = 7'd92;
  localparam logic [GLYPH_W-1:0] GLYPH_GHE    = 7'd93;
  localparam logic [GLYPH_W-1:0] GLYPH_DEGREE = 7'd94;
  localparam logic [GLYPH_W-1:0] GLYPH_WIDE   = 7'd89;

  // Narrow glyphs: one column.
  localparam logic [GLYPH_W-1:0] GLYPH_N1 = 7'd27;
  localparam logic [GLYPH_W-1:0] GLYPH_N2 = 7'd33;
  localparam logic [GLYPH_W-1:0] GLYPH_N3 = 7'd38;
  localparam logic [GLYPH_W-1:0] GLYPH_N4 = 7'd40;
  localparam logic [GLYPH_W-1:0] GLYPH_N5 = 7'd52;
  localparam logic [GLYPH_W-1:0] GLYPH_N6 = 7'd53;
  // Two-column glyphs besides the blank.
  localparam logic [GLYPH_W-1:0] GLYPH_M1 = 7'd34;
  localparam logic [GLYPH_W-1:0] GLYPH_M2 = 7'd35;

  // Glyph widths.
  localparam logic [WIDTH_W-1:0] WIDTH_ONE   = 3'd1;
  localparam logic [WIDTH_W-1:0] WIDTH_TWO   = 3'd2;
  localparam logic [WIDTH_W-1:0] WIDTH_THREE = 3'd3;
  localparam logic [WIDTH_W-1:0] WIDTH_FOUR  = 3'd4;

  // Glyph attributes from the map.
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [WIDTH_W-1:0] width;
    logic               extra;
  } glyph_map_t;

  // One result word.
  typedef struct packed {
    logic [COUNT_W-1:0]       char_index;
    logic signed [XPOS_W-1:0] x_position;
    logic [WIDTH_W-1:0]       glyph_width;
    logic [GLYPH_W-1:0]       glyph_index;
    logic                     extra_column;
    logic                     line_end;
  } result_t;

endpackage

// ===== hw/rtl/utf8_tiny_font_glyph_layout_top.sv =====
// ----------------------------------------------------------------------------
// utf8_tiny_font_glyph_layout_top
// UTF-8 text line to 3x5 font glyph placement, one word per glyph or line end.
// ----------------------------------------------------------------------------
// The block takes one text byte per clock cycle while in_tready is high and
// presents the glyph word that the byte completes: one byte sits in the
// input register, the decode and the line state update run in one pass,
// and the word lands in the output register. Bytes that open or continue a
// multi-byte sequence, and lead bytes past the line length limit, give no
// word. A 0x00 or 0x0A byte gives a word with tlast high and clears the
// line. One byte per cycle, unless the output stalls, rests on the single
// decode stage between the two registers; a stalled output holds the input
// side only once both are full. base_x must be written on the configuration
// channel while no text is in flight; the block does not enforce this.
module utf8_tiny_font_glyph_layout_top #(
  parameter int LINE_BYTES = utf8tf_pkg::LINE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: base_x
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,     // [7:0] base_x
  // Text bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] text_byte
  // Glyph words
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [6:0] glyph_index, [9:7] glyph_width,
                                    // [22:10] x_position, [31:23] char_index
  output logic        out_tuser,    // [0] extra_column
  output logic        out_tlast     // line_end
);
  import utf8tf_pkg::*;

  logic signed [BASE_W-1:0] base_r;
  logic                     in_v_r;
  logic [7:0]               in_byte_r;
  logic                     out_v_r;
  result_t                  out_r;
  logic                     adv;
  logic                     res_hit;
  result_t                  res;

  // Configuration register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_valid) begin
      base_r <= $signed(cfg_data);
    end
  end

  // The byte in hand moves on when the output register is free or emptying.
  assign adv       = !out_v_r || out_tready;
  assign in_tready = !in_v_r || adv;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  utf8tf_line_state #(
    .LINE_BYTES (LINE_BYTES)
  ) u_line (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (in_v_r && adv),
    .text_byte (in_byte_r),
    .base_x    (base_r),
    .res_hit   (res_hit),
    .res       (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r && res_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_v_r && res_hit) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {out_r.char_index, out_r.x_position,
                       out_r.glyph_width, out_r.glyph_index};
  assign out_tuser  = out_r.extra_column;
  assign out_tlast  = out_r.line_end;

endmodule

// ===== hw/rtl/utf8tf_glyph_map.sv =====
// ----------------------------------------------------------------------------
// utf8tf_glyph_map
// Maps a packed one- or two-byte code to a font glyph, its width and the
// wide-letter flag.
// ----------------------------------------------------------------------------
module utf8tf_glyph_map (
  input  logic [15:0]             code,
  output utf8tf_pkg::glyph_map_t  attr
);
  import utf8tf_pkg::*;

  logic [7:0]         lo;
  logic [7:0]         idx;
  logic [GLYPH_W-1:0] g;
  logic [WIDTH_W-1:0] w;
  logic               ext;

  assign lo = code[7:0];

  // Glyph number from the code ranges.
  always_comb begin
    idx = 8'd0;
    g   = GLYPH_BLANK;
    if ((code >= CODE_UP_A && code <= CODE_UP_Z) ||
        (code >= CODE_LO_A && code <= CODE_LO_Z)) begin
      g = {2'b00, lo[4:0]};
    end else if (code >= CODE_PUNCT_LO && code <= CODE_PUNCT_HI) begin
      idx = lo - CODE_PUNCT_LO[7:0] + {1'b0, GLYPH_PUNCT0};
      g   = idx[GLYPH_W-1:0];
    end else if (code >= CODE_CYR_UP_LO && code <= CODE_CYR_UP_HI) begin
      idx = lo - CODE_CYR_UP_LO[7:0] + {1'b0, GLYPH_CYR0};
      g   = idx[GLYPH_W-1:0];
    end else if (code >= CODE_CYR_LA_LO && code <= CODE_CYR_LA_HI) begin
      idx = lo - CODE_CYR_LA_LO[7:0] + {1'b0, GLYPH_CYR0};
      g   = idx[GLYPH_W-1:0];
    end else if (code >= CODE_CYR_LB_LO && code <= CODE_CYR_LB_HI) begin
      idx = lo - CODE_CYR_LB_LO[7:0] + {1'b0, GLYPH_CYR16};
      g   = idx[GLYPH_W-1:0];
    end else if (code == CODE_IO_UP || code == CODE_IO_LO) begin
      g = GLYPH_IO;
    end else if (code == CODE_YE_UP || code == CODE_YE_LO) begin
      g = GLYPH_YE;
    end else if (code == CODE_I_UP || code == CODE_I_LO) begin
      g = GLYPH_I;
    end else if (code == CODE_YI_UP || code == CODE_YI_LO) begin
      g = GLYPH_YI;
    end else if (code == CODE_GHE_UP || code == CODE_GHE_LO) begin
      g = GLYPH_GHE;
    end else if (code == CODE_DEGREE) begin
      g = GLYPH_DEGREE;
    end
  end

  // Width and the added column of the wide letter.
  always_comb begin
    w   = WIDTH_THREE;
    ext = 1'b0;
    if (g == GLYPH_N1 || g == GLYPH_N2 || g == GLYPH_N3 ||
        g == GLYPH_N4 || g == GLYPH_N5 || g == GLYPH_N6) begin
      w = WIDTH_ONE;
    end
    if (g == GLYPH_BLANK || g == GLYPH_M1 || g == GLYPH_M2) begin
      w = WIDTH_TWO;
    end
    // The delete code shows as a one-column blank.
    if (code == CODE_DEL) begin
      w = WIDTH_ONE;
    end
    if (g == GLYPH_WIDE) begin
      w   = WIDTH_FOUR;
      ext = 1'b1;
    end
  end

  assign attr.glyph = g;
  assign attr.width = w;
  assign attr.extra = ext;

endmodule

// ===== hw/rtl/utf8tf_line_state.sv =====
// ----------------------------------------------------------------------------
// utf8tf_line_state
// Running line state: gathers UTF-8 sequences, places glyphs and keeps the
// column offset, character count and line byte count.
// ----------------------------------------------------------------------------
module utf8tf_line_state #(
  parameter int LINE_BYTES = utf8tf_pkg::LINE_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step,
  input  logic [7:0]                        text_byte,
  input  logic signed [utf8tf_pkg::BASE_W-1:0] base_x,
  output logic                              res_hit,
  output utf8tf_pkg::result_t               res
);
  import utf8tf_pkg::*;

  localparam int SEEN_W = $clog2(LINE_BYTES + 1);
  localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(LINE_BYTES);

  logic [7:0]         lead_r,    lead_nxt;
  logic               long_r,    long_nxt;
  logic [1:0]         pend_r,    pend_nxt;
  logic [OFFS_W-1:0]  offs_r,    offs_nxt;
  logic [COUNT_W-1:0] count_r,   count_nxt;
  logic [SEEN_W-1:0]  seen_r,    seen_nxt;

  logic               term;
  logic               place;
  logic [15:0]        code;
  glyph_map_t         attr;
  logic [OFFS_W:0]    offs_sum;
  logic signed [XPOS_W-1:0] x_now;

  assign term = (text_byte == BYTE_NUL) || (text_byte == BYTE_LF);

  // Column where the next glyph or the line end lands.
  assign x_now = XPOS_W'(base_x) + $signed({1'b0, offs_r});

  utf8tf_glyph_map u_map (
    .code (code),
    .attr (attr)
  );

  assign offs_sum = {1'b0, offs_r} + (OFFS_W+1)'(attr.width) + (OFFS_W+1)'(1);

  // Sequence assembly and line bookkeeping for the byte in hand.
  always_comb begin
    lead_nxt  = lead_r;
    long_nxt  = long_r;
    pend_nxt  = pend_r;
    offs_nxt  = offs_r;
    count_nxt = count_r;
    seen_nxt  = seen_r;
    place     = 1'b0;
    code      = {8'h00, text_byte};
    if (term) begin
      lead_nxt  = 8'h00;
      long_nxt  = 1'b0;
      pend_nxt  = 2'd0;
      offs_nxt  = '0;
      count_nxt = '0;
      seen_nxt  = '0;
    end else if (pend_r != 2'd0) begin
      // Continuation byte, value not checked.
      pend_nxt = pend_r - 2'd1;
      if (seen_r < SEEN_MAX) begin
        seen_nxt = seen_r + SEEN_W'(1);
      end
      // Three- and four-byte codes match no glyph; code zero maps to blank.
      code  = long_r ? 16'h0000 : {lead_r, text_byte};
      place = (pend_r == 2'd1);
    end else if (seen_r < SEEN_MAX) begin
      seen_nxt = seen_r + SEEN_W'(1);
      if (text_byte[7:5] == 3'b110) begin
        pend_nxt = 2'd1;
        lead_nxt = text_byte;
        long_nxt = 1'b0;
      end else if (text_byte[7:4] == 4'b1110) begin
        pend_nxt = 2'd2;
        lead_nxt = text_byte;
        long_nxt = 1'b1;
      end else if (text_byte[7:3] == 5'b11110) begin
        pend_nxt = 2'd3;
        lead_nxt = text_byte;
        long_nxt = 1'b1;
      end else begin
        place = 1'b1;
      end
    end
    // Advance the offset and count when a glyph is placed.
    if (place) begin
      offs_nxt = (offs_sum > {1'b0, OFFSET_MAX}) ? OFFSET_MAX : offs_sum[OFFS_W-1:0];
      if (count_r < COUNT_MAX) begin
        count_nxt = count_r + COUNT_W'(1);
      end
    end
  end

  // Result word for this byte.
  always_comb begin
    res_hit          = term || place;
    res.char_index   = count_r;
    res.x_position   = x_now;
    res.line_end     = term;
    res.glyph_index  = term ? GLYPH_BLANK : attr.glyph;
    res.glyph_width  = term ? '0 : attr.width;
    res.extra_column = term ? 1'b0 : attr.extra;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r  <= 8'h00;
      long_r  <= 1'b0;
      pend_r  <= 2'd0;
      offs_r  <= '0;
      count_r <= '0;
      seen_r  <= '0;
    end else if (step) begin
      lead_r  <= lead_nxt;
      long_r  <= long_nxt;
      pend_r  <= pend_nxt;
      offs_r  <= offs_nxt;
      count_r <= count_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

// ===== hw/rtl/utf8tf_checker.sv =====
// ----------------------------------------------------------------------------
// utf8tf_checker
// Port-level checks of the glyph layout block, bound to its top level.
// ----------------------------------------------------------------------------
module utf8tf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);
  import utf8tf_pkg::*;

  // A stalled word holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output word changed");

  // Reset leaves no word on the output.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A line-end word carries no glyph.
  a_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[9:0] == 10'd0 && !out_tuser)
    else $error("line-end word carries glyph fields");

  // The added column belongs only to the wide letter at width four.
  a_wide: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[6:0] == GLYPH_WIDE &&
    out_tdata[9:7] == WIDTH_FOUR)
    else $error("extra column on a glyph that is not the wide letter");

  // A placed glyph is one to four columns wide.
  a_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[9:7] != 3'd0 && out_tdata[9:7] <= WIDTH_FOUR)
    else $error("glyph width out of range");

endmodule

bind utf8_tiny_font_glyph_layout_top utf8tf_checker u_utf8tf_checker (.*);
